[hdl/utf8sd_pkg.sv]
// Shared types, constants and helpers for the UTF-8 stream decoder.
// No dependencies.
package utf8sd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CpW    = 32;
  localparam int unsigned LenW   = 3;

  // Lead byte limits of the original six-byte scheme
  localparam logic [ByteW-1:0] Lead1Max = 8'd127;
  localparam logic [ByteW-1:0] Lead2Max = 8'd223;
  localparam logic [ByteW-1:0] Lead3Max = 8'd239;
  localparam logic [ByteW-1:0] Lead4Max = 8'd247;
  localparam logic [ByteW-1:0] Lead5Max = 8'd251;
  localparam logic [ByteW-1:0] Lead6Max = 8'd253;

  localparam logic [CpW-1:0] LeadBias = 32'd192;
  localparam logic [CpW-1:0] ContBias = 32'd128;

  // Length codes; zero marks a bad lead
  localparam logic [LenW-1:0] LenBad = 3'd0;
  localparam logic [LenW-1:0] LenOne = 3'd1;
  localparam logic [LenW-1:0] LenMaxShift = 3'd4;

  typedef struct packed {
    logic [LenW-1:0] bytes_left;
    logic [CpW-1:0]  partial_value;
    logic [LenW-1:0] total_length;
  } dec_state_t;

  typedef struct packed {
    logic            valid;
    logic [CpW-1:0]  code_point;
    logic [LenW-1:0] seq_length;
    logic            bad_lead;
  } dec_result_t;

  function automatic logic [LenW-1:0] lead_length(input logic [ByteW-1:0] b);
    logic [LenW-1:0] n;
    if (b <= Lead1Max)      n = 3'd1;
    else if (b <= Lead2Max) n = 3'd2;
    else if (b <= Lead3Max) n = 3'd3;
    else if (b <= Lead4Max) n = 3'd4;
    else if (b <= Lead5Max) n = 3'd5;
    else if (b <= Lead6Max) n = 3'd6;
    else                    n = LenBad;
    return n;
  endfunction

  // v << (6*k), k limited to 0..5
  function automatic logic [CpW-1:0] shl6(input logic [CpW-1:0] v,
                                          input logic [LenW-1:0] k);
    logic [CpW-1:0] r;
    unique case (k)
      3'd0:    r = v;
      3'd1:    r = v << 6;
      3'd2:    r = v << 12;
      3'd3:    r = v << 18;
      3'd4:    r = v << 24;
      default: r = v << 30;
    endcase
    return r;
  endfunction

endpackage

[hdl/utf8_stream_decoder_top.sv]
// Top level of the UTF-8 stream decoder (original six-byte scheme).
// Depends on utf8sd_pkg and utf8sd_step.
//
//  channel | signals                                   | dir
//  in      | in_valid_i, in_ready_o, in_byte_i         | in
//  out     | out_valid_o, out_ready_i, code_point_o,   | out
//          | seq_length_o, bad_lead_o                  |
//
// One byte per cycle while in_ready_o is high: the decode step sits
// between the sequence state registers and the result register.
// Reset clears the open sequence and the result valid flag.
// A held result only stalls input when out_ready_i is low; a waiting
// result is replaced in the same cycle it is taken.
module utf8_stream_decoder_top import utf8sd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ByteW-1:0] in_byte_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [CpW-1:0]   code_point_o,
  output logic [LenW-1:0]  seq_length_o,
  output logic             bad_lead_o
);

  dec_state_t  state_q, state_d;
  dec_result_t step_res;
  logic        out_valid_q;
  logic [CpW-1:0]  code_point_q;
  logic [LenW-1:0] seq_length_q;
  logic        bad_lead_q;
  logic        accept;

  utf8sd_step u_step (
    .state_i  (state_q),
    .byte_i   (in_byte_i),
    .state_o  (state_d),
    .result_o (step_res)
  );

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        state_q <= state_d;
      end
      if (accept) begin
        out_valid_q <= step_res.valid;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && step_res.valid) begin
      code_point_q <= step_res.code_point;
      seq_length_q <= step_res.seq_length;
      bad_lead_q   <= step_res.bad_lead;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign code_point_o = code_point_q;
  assign seq_length_o = seq_length_q;
  assign bad_lead_o   = bad_lead_q;

endmodule

[hdl/utf8sd_step.sv]
// Combinational decode step: one byte against the open-sequence state.
// Depends on utf8sd_pkg.
module utf8sd_step import utf8sd_pkg::*; (
  input  dec_state_t       state_i,
  input  logic [ByteW-1:0] byte_i,
  output dec_state_t       state_o,
  output dec_result_t      result_o
);

  logic [LenW-1:0] lead_n;
  logic [LenW-1:0] lead_k;
  logic [LenW-1:0] cont_k;
  logic [LenW-1:0] left_dec;
  logic [CpW-1:0]  byte_ext;
  logic [CpW-1:0]  lead_term;
  logic [CpW-1:0]  cont_sum;

  assign byte_ext  = {{(CpW-ByteW){1'b0}}, byte_i};
  assign lead_n    = lead_length(byte_i);
  assign lead_k    = lead_n - 3'd1;
  assign lead_term = shl6(byte_ext - LeadBias, lead_k);
  assign left_dec  = state_i.bytes_left - 3'd1;
  assign cont_k    = (left_dec > LenMaxShift) ? LenMaxShift : left_dec;
  assign cont_sum  = state_i.partial_value + shl6(byte_ext - ContBias, cont_k);

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    if (state_i.bytes_left == '0) begin
      if (lead_n == LenBad) begin
        result_o.valid      = 1'b1;
        result_o.seq_length = LenOne;
        result_o.bad_lead   = 1'b1;
      end else if (lead_n == LenOne) begin
        result_o.valid      = 1'b1;
        result_o.code_point = byte_ext;
        result_o.seq_length = LenOne;
      end else begin
        state_o.partial_value = lead_term;
        state_o.bytes_left    = lead_k;
        state_o.total_length  = lead_n;
      end
    end else begin
      state_o.bytes_left    = left_dec;
      state_o.partial_value = cont_sum;
      if (left_dec == '0) begin
        result_o.valid        = 1'b1;
        result_o.code_point   = cont_sum;
        result_o.seq_length   = state_i.total_length;
        state_o.partial_value = '0;
        state_o.total_length  = '0;
      end
    end
  end

endmodule
